FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the mip box downsampler.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Base form: property checked on every rising clk edge, off while in reset.
`define MBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent and consequent in the same cycle.
`define MBD_ASSERT_SAME(lbl, ante, cons, msg) \
  `MBD_ASSERT(lbl, (ante) |-> (cons), msg)

// Consequent in the cycle after the antecedent.
`define MBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `MBD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/mbd_pkg.sv
// Package for the mip box downsampler: field widths, codes and the
// accumulator control struct. No dependencies.
package mbd_pkg;

  localparam int MAX_TEXELS_DEF = 4096;

  localparam int DIM_W   = 13;  // source dimension registers
  localparam int ODIM_W  = 12;  // output dimensions, up to 4095
  localparam int COORD_W = 11;
  localparam int IDX_W   = 12;
  localparam int TEXEL_W = 32;
  localparam int FMT_W   = 3;
  localparam int SHIFT_W = 2;   // sample count 1..8 -> shift 0..3
  localparam int HD_W    = 2 * DIM_W;       // h*d
  localparam int XB_W    = ODIM_W + HD_W;   // 2x * h*d
  localparam int YB_W    = ODIM_W + DIM_W;  // 2y * d
  localparam int LIN_W   = XB_W + 2;        // full linear address with carries
  localparam int SUM16_W = 19;              // eight 16-bit samples
  localparam int SUM8_W  = 11;              // eight 8-bit samples
  localparam int NCH     = 4;

  // stream packing
  localparam int S_DATA_W = 80;  // 77 bits of fields, padded to bytes
  localparam int IDX_LSB  = 0;
  localparam int VAL_LSB  = IDX_LSB + IDX_W;
  localparam int OX_LSB   = VAL_LSB + TEXEL_W;
  localparam int OY_LSB   = OX_LSB + COORD_W;
  localparam int OZ_LSB   = OY_LSB + COORD_W;

  // configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_SRC_DEPTH  = 2'd2,
    REG_PIX_FORMAT = 2'd3
  } reg_idx_t;

  localparam logic [FMT_W-1:0] FMT_R8      = 3'd0;
  localparam logic [FMT_W-1:0] FMT_RG8     = 3'd1;
  localparam logic [FMT_W-1:0] FMT_RGB8    = 3'd2;
  localparam logic [FMT_W-1:0] FMT_RGBA8   = 3'd3;
  localparam logic [FMT_W-1:0] FMT_DEPTH16 = 3'd4;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_AVG  = 1'b1;

  localparam logic STAT_OK  = 1'b0;
  localparam logic STAT_OOB = 1'b1;

  typedef struct packed {
    logic clear;  // start of a new request
    logic add;    // read data of a sample is valid this cycle
  } acc_ctl_t;

endpackage

FILE: rtl/mbd_store.sv
// Texel store: synchronous RAM with one write and one read port, registered read.
// Uses mbd_pkg for the word width.
module mbd_store #(
  parameter int DEPTH  = mbd_pkg::MAX_TEXELS_DEF,
  parameter int ADDR_W = $clog2(mbd_pkg::MAX_TEXELS_DEF)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [mbd_pkg::TEXEL_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [mbd_pkg::TEXEL_W-1:0] rd_data
);
  import mbd_pkg::*;

  logic [TEXEL_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/mbd_accum.sv
// Per-channel sample accumulator and shift/format stage.
// Uses mbd_pkg (widths, format codes, acc_ctl_t).
module mbd_accum (
  input  logic                        clk,
  input  mbd_pkg::acc_ctl_t           ctl,
  input  logic [mbd_pkg::TEXEL_W-1:0] rd_data,
  input  logic [mbd_pkg::FMT_W-1:0]   fmt,
  input  logic [mbd_pkg::SHIFT_W-1:0] shift,
  output logic [mbd_pkg::TEXEL_W-1:0] result
);
  import mbd_pkg::*;

  logic [SUM16_W-1:0] sum16;
  logic [SUM8_W-1:0]  sum8 [NCH];
  logic [SUM16_W-1:0] avg16;
  logic [SUM8_W-1:0]  avg8 [NCH];

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      sum16 <= '0;
      for (int c = 0; c < NCH; c++) sum8[c] <= '0;
    end else if (ctl.add) begin
      sum16 <= sum16 + SUM16_W'(rd_data[15:0]);
      for (int c = 0; c < NCH; c++) begin
        sum8[c] <= sum8[c] + SUM8_W'(rd_data[8*c +: 8]);
      end
    end
  end

  always_comb begin
    avg16  = sum16 >> shift;
    for (int c = 0; c < NCH; c++) avg8[c] = sum8[c] >> shift;
    result = '0;
    if (fmt == FMT_DEPTH16) begin
      result[15:0] = avg16[15:0];
    end else begin
      for (int c = 0; c < NCH; c++) begin
        // unknown codes above depth behave as four channels
        if (fmt > FMT_DEPTH16 || fmt >= FMT_W'(c)) begin
          result[8*c +: 8] = avg8[c][7:0];
        end
      end
    end
  end

endmodule

FILE: rtl/mip_box_downsample_3d_core.sv
// Top level of the 2x2x2 box-filter mip downsampler: sequencer, config
// registers and stream ports. Uses mbd_pkg, mbd_store, mbd_accum, assert_macros.svh.
//
// The block holds one source mip level in a texel store of MAX_TEXELS 32-bit
// words, written by load words (tuser = 0) at linear address x*H*D + y*D + z.
// A request word (tuser = 1) names one texel of the next level; the block
// reads the up to eight in-bounds source texels one per cycle through the
// store's read port, sums each channel and divides by the sample count with a
// shift. A request holds the input side through acceptance, the address
// multiplies, the row bases, the store reads, the landing of the last read
// and the hand-off to the output register, which waits while an earlier
// result is unread. The output register decouples the sides: loads and the
// next request are taken while a result waits. A request outside the output
// level goes from the bounds check to the hand-off and returns zero with
// status 1. Dimension registers of 0 act as 1; format codes 5 to 7 act as RGBA8.
module mip_box_downsample_3d_core #(
  parameter int MAX_TEXELS = mbd_pkg::MAX_TEXELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input words
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // [11:0] texel_index, [43:12] texel_value, [54:44] out_x, [65:55] out_y,
  // [76:66] out_z, [79:77] zero
  input  logic [mbd_pkg::S_DATA_W-1:0] s_tdata,
  // [0] req_type
  input  logic                         s_tuser,
  // result words
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // [31:0] average_value
  output logic [mbd_pkg::TEXEL_W-1:0]  m_tdata,
  // [0] status
  output logic                         m_tuser,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mbd_pkg::PADDR_W-1:0]  paddr,
  input  logic [mbd_pkg::PDATA_W-1:0]  pwdata,
  output logic [mbd_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import mbd_pkg::*;

`include "assert_macros.svh"

  localparam int ADDR_W = $clog2(MAX_TEXELS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,  // bounds check, h*d and 2y*d
    S_XB    = 7'b0000100,  // 2x*h*d
    S_BASE  = 7'b0001000,  // second row bases
    S_RUN   = 7'b0010000,  // up to eight store reads
    S_DRAIN = 7'b0100000,  // last read data lands in the sums
    S_FIN   = 7'b1000000   // wait for the output register
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [DIM_W-1:0] src_width, src_height, src_depth;
  logic [FMT_W-1:0] pix_format;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(1);
      src_height <= DIM_W'(1);
      src_depth  <= DIM_W'(1);
      pix_format <= FMT_RGBA8;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_SRC_WIDTH:  src_width  <= pwdata[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= pwdata[DIM_W-1:0];
        REG_SRC_DEPTH:  src_depth  <= pwdata[DIM_W-1:0];
        REG_PIX_FORMAT: pix_format <= pwdata[FMT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_SRC_WIDTH:  prdata = PDATA_W'(src_width);
      REG_SRC_HEIGHT: prdata = PDATA_W'(src_height);
      REG_SRC_DEPTH:  prdata = PDATA_W'(src_depth);
      REG_PIX_FORMAT: prdata = PDATA_W'(pix_format);
      default:        prdata = '0;
    endcase
  end

  // input field views
  logic [IDX_W-1:0]   in_idx;
  logic [TEXEL_W-1:0] in_val;
  logic               in_acc, in_load, in_req;

  assign in_idx  = s_tdata[IDX_LSB +: IDX_W];
  assign in_val  = s_tdata[VAL_LSB +: TEXEL_W];
  assign s_tready = (state == S_IDLE);
  assign in_acc  = s_tvalid && s_tready;
  assign in_load = in_acc && (s_tuser == REQ_LOAD);
  assign in_req  = in_acc && (s_tuser == REQ_AVG);

  // request context (payload, no reset)
  logic [COORD_W-1:0] ox, oy, oz;
  logic [DIM_W-1:0]   w_e, h_e, d_e;
  logic [HD_W-1:0]    hd;
  logic [XB_W-1:0]    xb0;
  logic [XB_W:0]      xb1;
  logic [YB_W-1:0]    yb0;
  logic [YB_W:0]      yb1;
  logic               in_x1, in_y1, in_z1, err;
  logic [SHIFT_W-1:0] shift;

  // output dims and bounds, from captured coordinates
  logic [ODIM_W-1:0] odx, ody, odz;
  logic              oob;

  assign odx = (w_e > DIM_W'(1)) ? w_e[DIM_W-1:1] : ODIM_W'(1);
  assign ody = (h_e > DIM_W'(1)) ? h_e[DIM_W-1:1] : ODIM_W'(1);
  assign odz = (d_e > DIM_W'(1)) ? d_e[DIM_W-1:1] : ODIM_W'(1);
  assign oob = ({1'b0, ox} >= odx) || ({1'b0, oy} >= ody) || ({1'b0, oz} >= odz);

  // sample walk
  logic [2:0]        smp;
  logic [LIN_W-1:0]  lin_addr;
  logic              smp_inb, rd_en, rd_pend;
  logic [ADDR_W-1:0] rd_addr;

  always_comb begin
    lin_addr = (smp[2] ? LIN_W'(xb1) : LIN_W'(xb0))
             + (smp[1] ? LIN_W'(yb1) : LIN_W'(yb0))
             + LIN_W'({oz, smp[0]});
    smp_inb  = (!smp[2] || in_x1) && (!smp[1] || in_y1) && (!smp[0] || in_z1);
    // in-bounds samples past the end of the store count but read as zero
    rd_en    = (state == S_RUN) && smp_inb && (lin_addr < LIN_W'(MAX_TEXELS));
    rd_addr  = lin_addr[ADDR_W-1:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_req) state_next = S_CHECK;
      S_CHECK: state_next = oob ? S_FIN : S_XB;
      S_XB:    state_next = S_BASE;
      S_BASE:  state_next = S_RUN;
      S_RUN:   if (smp == 3'd7) state_next = S_DRAIN;
      S_DRAIN: state_next = S_FIN;
      S_FIN:   if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      smp     <= '0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_en;
      if (state == S_RUN) begin
        smp <= smp + 3'd1;
      end else begin
        smp <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ox  <= s_tdata[OX_LSB +: COORD_W];
        oy  <= s_tdata[OY_LSB +: COORD_W];
        oz  <= s_tdata[OZ_LSB +: COORD_W];
        w_e <= (src_width  == '0) ? DIM_W'(1) : src_width;
        h_e <= (src_height == '0) ? DIM_W'(1) : src_height;
        d_e <= (src_depth  == '0) ? DIM_W'(1) : src_depth;
      end
      S_CHECK: begin
        err   <= oob;
        hd    <= h_e * d_e;
        yb0   <= {oy, 1'b0} * d_e;
        in_x1 <= {1'b0, ox, 1'b1} < w_e;
        in_y1 <= {1'b0, oy, 1'b1} < h_e;
        in_z1 <= {1'b0, oz, 1'b1} < d_e;
      end
      S_XB: begin
        xb0   <= {ox, 1'b0} * hd;
        shift <= SHIFT_W'(in_x1) + SHIFT_W'(in_y1) + SHIFT_W'(in_z1);
      end
      S_BASE: begin
        xb1 <= (XB_W+1)'(xb0) + (XB_W+1)'(hd);
        yb1 <= (YB_W+1)'(yb0) + (YB_W+1)'(d_e);
      end
      default: ;
    endcase
  end

  // store and accumulator
  logic [TEXEL_W-1:0] rd_data, acc_result;
  acc_ctl_t           acc_ctl;
  logic               st_wr;

  assign st_wr = in_load && (32'(in_idx) < 32'(MAX_TEXELS));
  assign acc_ctl.clear = in_req;
  assign acc_ctl.add   = rd_pend;

  mbd_store #(
    .DEPTH  (MAX_TEXELS),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (st_wr),
    .wr_addr (ADDR_W'(in_idx)),
    .wr_data (in_val),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  mbd_accum u_accum (
    .clk     (clk),
    .ctl     (acc_ctl),
    .rd_data (rd_data),
    .fmt     (pix_format),
    .shift   (shift),
    .result  (acc_result)
  );

  // output register
  logic out_load;
  assign out_load = (state == S_FIN) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= err ? '0 : acc_result;
      m_tuser <= err ? STAT_OOB : STAT_OK;
    end
  end

  `MBD_ASSERT_NEXT(a_req_to_check, in_req, state == S_CHECK, "request did not start check")
  `MBD_ASSERT_SAME(a_rd_in_run, rd_en, state == S_RUN, "store read outside sample walk")
  `MBD_ASSERT_SAME(a_add_after_run, acc_ctl.add, state == S_RUN || state == S_DRAIN, "stray add")
  `MBD_ASSERT_SAME(a_oob_zero, m_tvalid && m_tuser, m_tdata == '0, "error word not zero")
  `MBD_ASSERT_NEXT(a_walk_drain, state == S_RUN && smp == 3'd7, state == S_DRAIN, "walk overrun")

endmodule
